FILE: hdl/npos_pkg.sv
// Package for the nearest-point-on-segment block: item structs, case codes,
// internal stage structs and fixed datapath widths. No dependencies.
`default_nettype none
package npos_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int ProdW  = 66;
  localparam int DotW   = 67;
  localparam int LenW   = 66;
  localparam int RemW   = 67;
  localparam int MagW   = 33;

  typedef enum logic [1:0] {
    CaseInterior = 2'd0,
    CaseStart    = 2'd1,
    CaseEnd      = 2'd2,
    CaseDegen    = 2'd3
  } npos_case_e;

  typedef struct packed {
    logic signed [CoordW-1:0] query_x;
    logic signed [CoordW-1:0] query_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } npos_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
    logic        [1:0]        case_code;
  } npos_out_t;

  // Divider working values: partial remainder and squared length.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [LenW-1:0] len;
  } npos_div_t;

  // Side data that rides along the divider.
  typedef struct packed {
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic        [MagW-1:0]   dmag_x;
    logic        [MagW-1:0]   dmag_y;
    logic                     neg_x;
    logic                     neg_y;
    npos_case_e               code;
  } npos_side_t;

endpackage
`default_nettype wire

FILE: hdl/npos_front.sv
// Front end: differences, the four products, dot and squared length, and
// the case classification. Three register stages. Depends on npos_pkg.
`default_nettype none
module npos_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  npos_pkg::npos_in_t     data_i,
  output logic                   valid_o,
  output npos_pkg::npos_div_t    div_o,
  output npos_pkg::npos_side_t   side_o
);
  import npos_pkg::*;

  logic valid_a_q, valid_b_q, valid_c_q;

  logic signed [DiffW-1:0]  ax_q, ay_q, cx_q, cy_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                     degen_q;

  logic signed [ProdW-1:0]  pax_q, pay_q, pcx_q, pcy_q;
  logic signed [DiffW-1:0]  cx_b_q, cy_b_q;
  logic signed [CoordW-1:0] sx_b_q, sy_b_q, ex_b_q, ey_b_q;
  logic                     degen_b_q;

  logic signed [DotW-1:0]   dot_w;
  logic        [LenW-1:0]   len_w;
  npos_case_e               code_w;
  npos_div_t                div_d, div_q;
  npos_side_t               side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= DiffW'(data_i.query_x) - DiffW'(data_i.start_x);
      ay_q    <= DiffW'(data_i.query_y) - DiffW'(data_i.start_y);
      cx_q    <= DiffW'(data_i.end_x) - DiffW'(data_i.start_x);
      cy_q    <= DiffW'(data_i.end_y) - DiffW'(data_i.start_y);
      sx_q    <= data_i.start_x;
      sy_q    <= data_i.start_y;
      ex_q    <= data_i.end_x;
      ey_q    <= data_i.end_y;
      degen_q <= (data_i.end_x == data_i.start_x) && (data_i.end_y == data_i.start_y);

      pax_q     <= ax_q * cx_q;
      pay_q     <= ay_q * cy_q;
      pcx_q     <= cx_q * cx_q;
      pcy_q     <= cy_q * cy_q;
      cx_b_q    <= cx_q;
      cy_b_q    <= cy_q;
      sx_b_q    <= sx_q;
      sy_b_q    <= sy_q;
      ex_b_q    <= ex_q;
      ey_b_q    <= ey_q;
      degen_b_q <= degen_q;

      div_q  <= div_d;
      side_q <= side_d;
    end
  end

  always_comb begin
    dot_w = {pax_q[ProdW-1], pax_q} + {pay_q[ProdW-1], pay_q};
    len_w = {1'b0, pcx_q[ProdW-2:0]} + {1'b0, pcy_q[ProdW-2:0]};
    if (degen_b_q) begin
      code_w = CaseDegen;
    end else if (dot_w[DotW-1]) begin
      code_w = CaseStart;
    end else if (dot_w[LenW-1:0] > len_w) begin
      code_w = CaseEnd;
    end else begin
      code_w = CaseInterior;
    end
    div_d.rem      = {1'b0, dot_w[LenW-1:0]};
    div_d.len      = len_w;
    side_d.base_x  = (code_w == CaseEnd) ? ex_b_q : sx_b_q;
    side_d.base_y  = (code_w == CaseEnd) ? ey_b_q : sy_b_q;
    side_d.dmag_x  = cx_b_q[DiffW-1] ? MagW'(-cx_b_q) : MagW'(cx_b_q);
    side_d.dmag_y  = cy_b_q[DiffW-1] ? MagW'(-cy_b_q) : MagW'(cy_b_q);
    side_d.neg_x   = cx_b_q[DiffW-1];
    side_d.neg_y   = cy_b_q[DiffW-1];
    side_d.code    = code_w;
  end

  assign valid_o = valid_c_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

FILE: hdl/npos_div_stage.sv
// One restoring division step: yields one quotient bit of t per stage.
// Depends on npos_pkg.
`default_nettype none
module npos_div_stage #(
  parameter int TW = 17
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  npos_pkg::npos_div_t    div_i,
  input  npos_pkg::npos_side_t   side_i,
  input  wire  [TW-1:0]          t_i,
  output logic                   valid_o,
  output npos_pkg::npos_div_t    div_o,
  output npos_pkg::npos_side_t   side_o,
  output logic [TW-1:0]          t_o
);
  import npos_pkg::*;

  logic            valid_q;
  logic            ge_w;
  logic [RemW-1:0] sub_w, rn_w;
  npos_div_t       div_d, div_q;
  npos_side_t      side_q;
  logic [TW-1:0]   t_q;

  always_comb begin
    ge_w      = div_i.rem >= {1'b0, div_i.len};
    sub_w     = div_i.rem - {1'b0, div_i.len};
    rn_w      = ge_w ? sub_w : div_i.rem;
    // The kept remainder is below len, so the doubled value still fits.
    div_d.rem = {rn_w[RemW-2:0], 1'b0};
    div_d.len = div_i.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_i;
      t_q    <= {t_i[TW-2:0], ge_w};
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign side_o  = side_q;
  assign t_o     = t_q;

endmodule
`default_nettype wire

FILE: hdl/npos_back.sv
// Back end: scales the direction by t, adds it to the start, selects the
// endpoint cases and saturates. Two register stages. Depends on npos_pkg.
`default_nettype none
module npos_back #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  npos_pkg::npos_side_t   side_i,
  input  wire  [FRAC_BITS:0]     t_i,
  output logic                   valid_o,
  output npos_pkg::npos_out_t    data_o
);
  import npos_pkg::*;

  localparam int PW = FRAC_BITS + 1 + MagW;
  localparam int SW = 35;
  localparam logic signed [40:0] SatHi = (41'sd1 <<< (COORD_BITS - 1)) - 41'sd1;
  localparam logic signed [40:0] SatLo = -SatHi - 41'sd1;

  logic              valid_m_q, valid_q;
  logic [PW-1:0]     prod_x_w, prod_y_w;
  logic [MagW-1:0]   off_x_q, off_y_q;
  npos_side_t        side_q;
  logic signed [SW-1:0] vx_w, vy_w;
  npos_out_t         data_d, data_q;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SW-1:0] v,
                                                   input logic interior);
    logic signed [40:0] w;
    w = 41'(v);
    if (w > SatHi) begin
      w = SatHi;
    end else if (w < SatLo) begin
      w = SatLo;
    end
    sat = interior ? w[CoordW-1:0] : w[CoordW-1:0];
  endfunction

  assign prod_x_w = PW'(t_i) * PW'(side_i.dmag_x);
  assign prod_y_w = PW'(t_i) * PW'(side_i.dmag_y);

  always_comb begin
    if (side_q.code == CaseInterior) begin
      vx_w = side_q.neg_x ? SW'(side_q.base_x) - SW'({1'b0, off_x_q})
                          : SW'(side_q.base_x) + SW'({1'b0, off_x_q});
      vy_w = side_q.neg_y ? SW'(side_q.base_y) - SW'({1'b0, off_y_q})
                          : SW'(side_q.base_y) + SW'({1'b0, off_y_q});
    end else begin
      vx_w = SW'(side_q.base_x);
      vy_w = SW'(side_q.base_y);
    end
    data_d.near_x    = sat(vx_w, side_q.code == CaseInterior);
    data_d.near_y    = sat(vy_w, side_q.code == CaseInterior);
    data_d.case_code = side_q.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_m_q <= valid_i;
      valid_q   <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_x_q <= prod_x_w[FRAC_BITS+MagW-1:FRAC_BITS];
      off_y_q <= prod_y_w[FRAC_BITS+MagW-1:FRAC_BITS];
      side_q  <= side_i;
      data_q  <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

FILE: hdl/nearest_point_on_segment.sv
// Throughput: one item per cycle while the output register is empty or being taken;
// the restoring divider has one stage per bit of t.
// The whole pipeline advances while the output register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
// Depends on npos_pkg, npos_front, npos_div_stage and npos_back.
`default_nettype none
module nearest_point_on_segment #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  npos_pkg::npos_in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output npos_pkg::npos_out_t   out_data_o
);
  import npos_pkg::*;

  localparam int TW = FRAC_BITS + 1;

  // A single advance signal moves every stage at once. The result register
  // at the end holds a finished item while the output side stalls; a new
  // item enters whenever that register is free or is being read this cycle.
  logic adv;

  logic       valid_s [0:TW];
  npos_div_t  div_s   [0:TW];
  npos_side_t side_s  [0:TW];
  logic [TW-1:0] t_s  [0:TW];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Front end: differences, products, dot and squared length, classification.
  npos_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (valid_s[0]),
    .div_o   (div_s[0]),
    .side_o  (side_s[0])
  );

  assign t_s[0] = '0;

  // Divider: t = floor(dot * 2^FRAC_BITS / len), most significant bit first.
  // Items that are not interior pass through and their t is ignored.
  for (genvar k = 0; k < TW; k++) begin : g_div
    npos_div_stage #(.TW(TW)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valid_s[k]),
      .div_i   (div_s[k]),
      .side_i  (side_s[k]),
      .t_i     (t_s[k]),
      .valid_o (valid_s[k+1]),
      .div_o   (div_s[k+1]),
      .side_o  (side_s[k+1]),
      .t_o     (t_s[k+1])
    );
  end

  // Back end: interpolation, endpoint selection and saturation.
  npos_back #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid_s[TW]),
    .side_i  (side_s[TW]),
    .t_i     (t_s[TW]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // An interior item never gets a t above one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[TW] && side_s[TW].code == CaseInterior |-> t_s[TW] <= (TW'(1) << FRAC_BITS))
    else $error("t above one for an interior item");

  // A stalled result is neither dropped nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // While stalled, the pipeline must not take new items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted during stall");

endmodule
`default_nettype wire
